// ===== rtl/nvs_pkg.sv =====
// Package for the note voice stack: command codes, item structs and the
// decoded request that passes from the front end to the sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nvs_pkg;

  localparam int NOTE_W  = 7;
  localparam int LEVEL_W = 7;
  localparam int CMD_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_SUS_ON  = 3'd2,
    CMD_SUS_OFF = 3'd3,
    CMD_RELEASE = 3'd4,
    CMD_TOUCH   = 3'd5,
    CMD_CLEAR   = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               stolen_valid;
    logic [NOTE_W-1:0]  stolen_note;
    logic               removed_valid;
    logic [NOTE_W-1:0]  deleted_note;
    logic [LEVEL_W-1:0] removed_level;
    logic               newest_valid;
    logic [NOTE_W-1:0]  newest_note;
    logic [3:0]         active_count;
    logic [3:0]         sustained_count;
    logic [LEVEL_W-1:0] peak_pressure;
    logic [LEVEL_W-1:0] recent_velocity;
    logic               note_sustained;
  } out_item_t;

  // one stored voice
  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] level;
  } voice_entry_t;

  // classified command; query sets no flag
  typedef struct packed {
    logic add;
    logic remove;
    logic touch;
    logic sus_on;
    logic sus_off;
    logic release_sus;
    logic clear;
  } op_flags_t;

  typedef struct packed {
    op_flags_t          op;
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] value;
  } op_req_t;

  typedef struct packed {
    logic    valid;
    op_req_t req;
  } req_chan_t;

endpackage

`default_nettype wire

// ===== rtl/note_voice_stack_unit.sv =====
// Note voice stack, last-note-priority voice allocator: an ordered stack of
// held notes, oldest first, kept as a ring in a small RAM. Items enter a
// two-deep request queue (push/full) and every item gives exactly one result
// through a two-deep result queue (empty/pop). The sequencer handles one
// request at a time and makes one pass over the held voices through the
// single read port of the voice RAM; an add that steals the oldest voice
// first reads it out in a steal state. Remove passes over the notes held
// before it. No clearing pass is needed after reset.
// Uses nvs_pkg, nvs_front and nvs_engine.
`timescale 1ns / 1ps
`default_nettype none

module note_voice_stack_unit #(
  parameter int VOICE_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire nvs_pkg::in_item_t  in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output nvs_pkg::out_item_t      out_item
);

  import nvs_pkg::*;

  req_chan_t req_chan;
  logic      req_take;

  nvs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .req_chan (req_chan),
    .req_take (req_take)
  );

  nvs_engine #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_chan  (req_chan),
    .req_take  (req_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/nvs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nvs_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/nvs_front.sv =====
// Front end: accepts input items into a two-entry request queue and
// classifies each command into operation flags. Uses nvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire nvs_pkg::in_item_t in_item,
  output nvs_pkg::req_chan_t     req_chan,
  input  wire logic              req_take
);

  import nvs_pkg::*;

  op_req_t    q_r [2];
  op_req_t    q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  op_req_t    dec;
  logic       push, pop;

  always_comb begin
    dec       = '0;
    dec.note  = in_item.note;
    dec.value = in_item.value;
    unique case (cmd_t'(in_item.cmd))
      CMD_ADD:     dec.op.add         = 1'b1;
      CMD_REMOVE:  dec.op.remove      = 1'b1;
      CMD_SUS_ON:  dec.op.sus_on      = 1'b1;
      CMD_SUS_OFF: dec.op.sus_off     = 1'b1;
      CMD_RELEASE: dec.op.release_sus = 1'b1;
      CMD_TOUCH:   dec.op.touch       = 1'b1;
      CMD_CLEAR:   dec.op.clear       = 1'b1;
      CMD_QUERY:   dec.op             = '0;
      default:     dec.op             = '0;
    endcase
  end

  assign in_full        = (cnt_r == 2'd2);
  assign push           = in_push && !in_full;
  assign pop            = req_take && (cnt_r != 2'd0);
  assign req_chan.valid = (cnt_r != 2'd0);
  assign req_chan.req   = q_r[0];

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q_nxt[0] = dec;
        end else begin
          q_nxt[1] = dec;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q_nxt[0] = q_r[1];
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        // advance the head and refill behind it
        if (cnt_r == 2'd1) begin
          q_nxt[0] = dec;
        end else begin
          q_nxt[0] = q_r[1];
          q_nxt[1] = dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/nvs_engine.sv =====
// Back end: sequencer that carries out one request over the voice table RAM
// (a ring addressed from a base pointer) and queues results two deep.
// Uses nvs_pkg and nvs_ram.
`timescale 1ns / 1ps
`default_nettype none

module nvs_engine #(
  parameter int VOICE_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nvs_pkg::req_chan_t req_chan,
  output logic                    req_take,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output nvs_pkg::out_item_t      out_item
);

  import nvs_pkg::*;

  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CW = $clog2(VOICE_COUNT + 1);
  localparam logic [CW:0]   V_SUM  = (CW+1)'(VOICE_COUNT);
  localparam logic [CW-1:0] V_CNT  = CW'(VOICE_COUNT);
  localparam logic [CW-1:0] ONE    = CW'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_STEAL, ST_SCAN, ST_DONE} state_t;

  // logical slot k relative to the ring base
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] b, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, b} + {1'b0, k};
    if (s >= V_SUM) begin
      s = s - V_SUM;
    end
    return s[IW-1:0];
  endfunction

  state_t             state_r, state_nxt;
  op_req_t            op_r, op_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  logic [CW-1:0]      sus_r, sus_nxt;
  logic [IW-1:0]      base_r, base_nxt;
  logic [LEVEL_W-1:0] vel_r, vel_nxt;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               dv_r, dv_nxt;
  logic [CW-1:0]      d_idx_r, d_idx_nxt;
  logic               found_r, found_nxt;
  logic [LEVEL_W-1:0] rm_level_r, rm_level_nxt;
  logic [NOTE_W-1:0]  newest_r, newest_nxt;
  logic               hit_r, hit_nxt;
  logic [LEVEL_W-1:0] acc_r, acc_nxt;
  logic               st_v_r, st_v_nxt;
  logic [NOTE_W-1:0]  st_n_r, st_n_nxt;

  out_item_t          oq_r [2];
  out_item_t          oq_nxt [2];
  logic [1:0]         oq_cnt_r, oq_cnt_nxt;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  voice_entry_t       ram_wdata;
  logic [$bits(voice_entry_t)-1:0] ram_rdata;
  voice_entry_t       ent;

  logic               iss, match, push, pop;
  logic [CW-1:0]      s_span, pos;
  logic [LEVEL_W-1:0] lvl;
  out_item_t          res;
  logic [CW+3:0]      held_x, sus_x;

  nvs_ram #(
    .WIDTH ($bits(voice_entry_t)),
    .DEPTH (VOICE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent    = voice_entry_t'(ram_rdata);
  assign iss    = (state_r == ST_SCAN) && (rd_idx_r < held_r);
  assign match  = (ent.note == op_r.note);
  assign s_span = (sus_r < held_r) ? sus_r : held_r;
  assign held_x = {4'b0000, held_r};
  assign sus_x  = {4'b0000, sus_r};

  always_comb begin
    res                 = '0;
    res.stolen_valid    = st_v_r;
    res.stolen_note     = st_n_r;
    res.removed_valid   = found_r;
    res.deleted_note    = found_r ? op_r.note : '0;
    res.removed_level   = rm_level_r;
    res.newest_valid    = (held_r != '0);
    res.newest_note     = newest_r;
    res.active_count    = held_x[3:0];
    res.sustained_count = sus_x[3:0];
    res.peak_pressure   = peak_r;
    res.recent_velocity = vel_r;
    res.note_sustained  = hit_r;
  end

  assign push     = (state_r == ST_DONE) && (oq_cnt_r != 2'd2);
  assign pop      = out_pop && (oq_cnt_r != 2'd0);
  assign req_take = (state_r == ST_IDLE) && req_chan.valid;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    held_nxt     = held_r;
    sus_nxt      = sus_r;
    base_nxt     = base_r;
    vel_nxt      = vel_r;
    peak_nxt     = peak_r;
    rd_idx_nxt   = rd_idx_r;
    dv_nxt       = 1'b0;
    d_idx_nxt    = rd_idx_r;
    found_nxt    = found_r;
    rm_level_nxt = rm_level_r;
    newest_nxt   = newest_r;
    hit_nxt      = hit_r;
    acc_nxt      = acc_r;
    st_v_nxt     = st_v_r;
    st_n_nxt     = st_n_r;
    ram_we       = 1'b0;
    ram_waddr    = base_r;
    ram_wdata    = '0;
    ram_raddr    = base_r;
    pos          = d_idx_r;
    lvl          = ent.level;

    unique case (state_r)
      ST_IDLE: begin
        if (req_take) begin
          op_nxt       = req_chan.req;
          st_v_nxt     = 1'b0;
          st_n_nxt     = '0;
          found_nxt    = 1'b0;
          rm_level_nxt = '0;
          newest_nxt   = '0;
          hit_nxt      = 1'b0;
          rd_idx_nxt   = '0;
          acc_nxt      = req_chan.req.op.remove ? '0 :
                         req_chan.req.op.touch  ? req_chan.req.value : peak_r;
          state_nxt    = ST_SCAN;
          if (req_chan.req.op.add) begin
            if (held_r == V_CNT) begin
              // read the oldest voice before it is overwritten
              ram_raddr = base_r;
              state_nxt = ST_STEAL;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = phys(base_r, held_r);
              ram_wdata.note  = req_chan.req.note;
              ram_wdata.level = req_chan.req.value;
              held_nxt        = held_r + ONE;
              vel_nxt         = req_chan.req.value;
            end
          end
          if (req_chan.req.op.sus_on) begin
            sus_nxt = held_r;
          end
          if (req_chan.req.op.sus_off) begin
            sus_nxt = '0;
          end
          if (req_chan.req.op.release_sus) begin
            base_nxt = phys(base_r, s_span);
            held_nxt = held_r - s_span;
            sus_nxt  = '0;
          end
          if (req_chan.req.op.clear) begin
            held_nxt = '0;
            sus_nxt  = '0;
            vel_nxt  = '0;
            peak_nxt = '0;
          end
        end
      end

      ST_STEAL: begin
        st_v_nxt        = 1'b1;
        st_n_nxt        = ent.note;
        ram_we          = 1'b1;
        ram_waddr       = base_r;
        ram_wdata.note  = op_r.note;
        ram_wdata.level = op_r.value;
        base_nxt        = phys(base_r, ONE);
        vel_nxt         = op_r.value;
        state_nxt       = ST_SCAN;
      end

      ST_SCAN: begin
        if (iss) begin
          ram_raddr  = phys(base_r, rd_idx_r);
          rd_idx_nxt = rd_idx_r + ONE;
          dv_nxt     = 1'b1;
        end
        if (dv_r) begin
          if (op_r.op.remove && !found_r && match) begin
            // drop the first match and keep its level
            found_nxt    = 1'b1;
            rm_level_nxt = ent.level;
          end else begin
            if (op_r.op.remove && found_r) begin
              pos       = d_idx_r - ONE;
              ram_we    = 1'b1;
              ram_waddr = phys(base_r, pos);
              ram_wdata = ent;
            end
            if (op_r.op.touch && match) begin
              lvl             = op_r.value;
              ram_we          = 1'b1;
              ram_waddr       = phys(base_r, d_idx_r);
              ram_wdata.note  = ent.note;
              ram_wdata.level = op_r.value;
            end
            if (lvl > acc_r) begin
              acc_nxt = lvl;
            end
            newest_nxt = ent.note;
            if (match && (pos < sus_r)) begin
              hit_nxt = 1'b1;
            end
          end
        end
        if (!iss) begin
          state_nxt = ST_DONE;
          if (op_r.op.remove && found_nxt) begin
            held_nxt = held_r - ONE;
          end
          if (op_r.op.remove || op_r.op.touch) begin
            peak_nxt = acc_nxt;
          end
        end
      end

      ST_DONE: begin
        if (push) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // result queue, head in slot 0
  always_comb begin
    oq_nxt     = oq_r;
    oq_cnt_nxt = oq_cnt_r;
    case ({push, pop})
      2'b10: begin
        if (oq_cnt_r == 2'd0) begin
          oq_nxt[0] = res;
        end else begin
          oq_nxt[1] = res;
        end
        oq_cnt_nxt = oq_cnt_r + 2'd1;
      end
      2'b01: begin
        oq_nxt[0]  = oq_r[1];
        oq_cnt_nxt = oq_cnt_r - 2'd1;
      end
      2'b11: begin
        oq_nxt[0] = res;
      end
      default: ;
    endcase
  end

  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_item  = oq_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      sus_r    <= '0;
      base_r   <= '0;
      vel_r    <= '0;
      peak_r   <= '0;
      dv_r     <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      sus_r    <= sus_nxt;
      base_r   <= base_nxt;
      vel_r    <= vel_nxt;
      peak_r   <= peak_nxt;
      dv_r     <= dv_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
    op_r       <= op_nxt;
    rd_idx_r   <= rd_idx_nxt;
    d_idx_r    <= d_idx_nxt;
    found_r    <= found_nxt;
    rm_level_r <= rm_level_nxt;
    newest_r   <= newest_nxt;
    hit_r      <= hit_nxt;
    acc_r      <= acc_nxt;
    st_v_r     <= st_v_nxt;
    st_n_r     <= st_n_nxt;
    oq_r       <= oq_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/note_voice_stack_unit_test.sv =====
// Self-checking testbench for note_voice_stack_unit: drives commands through
// the push/full request queue, pops results and checks them against a tracker.
// Depends on nvs_pkg and the note_voice_stack_unit RTL.
`timescale 1ns / 1ps

module note_voice_stack_unit_test;
  import nvs_pkg::*;

  localparam int VOICES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 1200;

  // Mirrors the voice stack and queues the result each request should produce.
  class voice_stack_tracker;
    voice_entry_t slots[VOICES];
    int unsigned held;
    int unsigned sustained;
    logic [6:0] last_velocity;
    logic [6:0] peak;
    out_item_t pending_results[$];
    int errors;

    function new();
      held = 0;
      sustained = 0;
      last_velocity = '0;
      peak = '0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int unsigned sustained_span();
      return (sustained > held) ? held : sustained;
    endfunction

    function logic [6:0] highest_level(logic [6:0] floor_level);
      logic [6:0] m;
      m = floor_level;
      for (int i = 0; i < held; i++)
        if (slots[i].level > m) m = slots[i].level;
      return m;
    endfunction

    function void note_request(in_item_t req);
      out_item_t r;
      int unsigned h;
      int unsigned span;
      int found;
      r = '0;
      h = held;
      found = -1;
      case (req.cmd)
        CMD_ADD: begin
          if (h >= VOICES) begin
            // steal the oldest voice, sustain count stays as it is
            r.stolen_valid = 1'b1;
            r.stolen_note = slots[0].note;
            for (int i = 0; i < VOICES - 1; i++) slots[i] = slots[i + 1];
            h = VOICES;
          end else begin
            h++;
          end
          held = h;
          last_velocity = req.value;
          slots[h - 1].note = req.note;
          slots[h - 1].level = req.value;
        end
        CMD_REMOVE: begin
          for (int i = 0; i < h; i++)
            if (found < 0 && slots[i].note == req.note) found = i;
          if (found >= 0) begin
            r.removed_valid = 1'b1;
            r.deleted_note = req.note;
            r.removed_level = slots[found].level;
            for (int i = found; i + 1 < h; i++) slots[i] = slots[i + 1];
            held = h - 1;
          end
          peak = highest_level('0);
        end
        CMD_SUS_ON: sustained = h;
        CMD_SUS_OFF: sustained = 0;
        CMD_RELEASE: begin
          span = sustained_span();
          for (int i = 0; i + span < h; i++) slots[i] = slots[i + span];
          held = h - span;
          sustained = 0;
        end
        CMD_TOUCH: begin
          for (int i = 0; i < h; i++)
            if (slots[i].note == req.note) slots[i].level = req.value;
          peak = highest_level(req.value);
        end
        CMD_CLEAR: begin
          held = 0;
          sustained = 0;
          last_velocity = '0;
          peak = '0;
        end
        default: ;
      endcase

      span = sustained_span();
      for (int i = 0; i < span; i++)
        if (slots[i].note == req.note) r.note_sustained = 1'b1;
      r.newest_valid = (held > 0);
      if (held > 0) r.newest_note = slots[held - 1].note;
      r.active_count = held[3:0];
      r.sustained_count = sustained[3:0];
      r.peak_pressure = peak;
      r.recent_velocity = last_velocity;
      pending_results.push_back(r);
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("stolen_valid", want.stolen_valid, got.stolen_valid);
      check_field("stolen_note", want.stolen_note, got.stolen_note);
      check_field("removed_valid", want.removed_valid, got.removed_valid);
      check_field("deleted_note", want.deleted_note, got.deleted_note);
      check_field("removed_level", want.removed_level, got.removed_level);
      check_field("newest_valid", want.newest_valid, got.newest_valid);
      check_field("newest_note", want.newest_note, got.newest_note);
      check_field("active_count", want.active_count, got.active_count);
      check_field("sustained_count", want.sustained_count, got.sustained_count);
      check_field("peak_pressure", want.peak_pressure, got.peak_pressure);
      check_field("recent_velocity", want.recent_velocity, got.recent_velocity);
      check_field("note_sustained", want.note_sustained, got.note_sustained);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;

  voice_stack_tracker tracker = new();
  int stall_cycles = 0;

  note_voice_stack_unit #(.VOICE_COUNT(VOICES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item)
  );

  always #6 clk = ~clk;

  // Returns at the edge where the request is taken.
  task automatic send_request(input cmd_t c, input logic [6:0] n, input logic [6:0] v);
    in_item_t req;
    req.cmd = c;
    req.note = n;
    req.value = v;
    in_item <= req;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  task automatic rest_sender(input int cycles);
    if (cycles > 0) begin
      in_push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Check results before noting the new request: a result never belongs to
  // a request taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) tracker.check_result(out_item);
      if (in_push && !in_full) tracker.note_request(in_item);
      if ((out_pop && !out_empty) || (in_push && !in_full)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("note_voice_stack_unit test failed");
        $finish;
      end
    end
  end

  // Result side: stall on its own pattern, with long hold-offs to fill the block.
  initial begin
    int mode;
    int seg_len;
    int rounds;
    rounds = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rounds++;
      if (rounds == 5 || $urandom_range(0, 19) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(100, 150)) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        seg_len = $urandom_range(20, 120);
        for (int i = 0; i < seg_len; i++) begin
          case (mode)
            0: out_pop <= 1'b1;
            1: out_pop <= 1'($urandom_range(0, 1));
            2: out_pop <= ($urandom_range(0, 3) == 0);
            default: out_pop <= ((i % 8) < 5);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [6:0] note_pool[8];
    int burst_left;
    int roll;
    cmd_t c;
    logic [6:0] n;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack: query, miss on remove, release and aftertouch with nothing held
    send_request(CMD_QUERY, 7'd127, 7'd127);
    send_request(CMD_REMOVE, 7'd5, 7'd0);
    send_request(CMD_RELEASE, 7'd0, 7'd0);
    send_request(CMD_TOUCH, 7'd0, 7'd99);
    // fill all voices, field extremes and a duplicate note
    send_request(CMD_ADD, 7'd0, 7'd127);
    send_request(CMD_ADD, 7'd127, 7'd0);
    send_request(CMD_ADD, 7'd60, 7'd64);
    send_request(CMD_ADD, 7'd60, 7'd1);
    send_request(CMD_ADD, 7'd85, 7'd100);
    send_request(CMD_ADD, 7'd42, 7'd42);
    send_request(CMD_ADD, 7'd1, 7'd126);
    send_request(CMD_ADD, 7'd126, 7'd85);
    send_request(CMD_SUS_ON, 7'd60, 7'd0);
    // steal when full, touch both duplicates, remove leaving sustain above held
    send_request(CMD_ADD, 7'd77, 7'd33);
    send_request(CMD_TOUCH, 7'd60, 7'd127);
    send_request(CMD_REMOVE, 7'd85, 7'd0);
    send_request(CMD_REMOVE, 7'd99, 7'd0);
    send_request(CMD_QUERY, 7'd60, 7'd0);
    send_request(CMD_RELEASE, 7'd0, 7'd0);
    send_request(CMD_SUS_OFF, 7'd77, 7'd0);
    send_request(CMD_ADD, 7'd10, 7'd20);
    send_request(CMD_SUS_ON, 7'd10, 7'd0);
    send_request(CMD_CLEAR, 7'd10, 7'd0);
    send_request(CMD_QUERY, 7'd10, 7'd0);

    // random traffic; a small note pool keeps removes and touches hitting
    burst_left = $urandom_range(1, 20);
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k % 150 == 0)
        foreach (note_pool[i]) note_pool[i] = 7'($urandom_range(0, 127));
      roll = $urandom_range(0, 99);
      if (roll < 32) c = CMD_ADD;
      else if (roll < 52) c = CMD_REMOVE;
      else if (roll < 64) c = CMD_TOUCH;
      else if (roll < 72) c = CMD_SUS_ON;
      else if (roll < 78) c = CMD_SUS_OFF;
      else if (roll < 86) c = CMD_RELEASE;
      else if (roll < 89) c = CMD_CLEAR;
      else c = CMD_QUERY;
      if ($urandom_range(0, 9) < 7) n = note_pool[$urandom_range(0, 7)];
      else n = 7'($urandom_range(0, 127));
      send_request(c, n, 7'($urandom_range(0, 127)));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        roll = $urandom_range(0, 9);
        if (roll == 9) rest_sender($urandom_range(10, 30));
        else if (roll >= 2) rest_sender($urandom_range(1, 6));
      end
    end
    in_push <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("note_voice_stack_unit test passed");
    end else begin
      $display("note_voice_stack_unit test failed");
    end
    $finish;
  end

endmodule

// ===== note_voice_stack_unit.f =====
rtl/nvs_pkg.sv
rtl/nvs_ram.sv
rtl/nvs_front.sv
rtl/nvs_engine.sv
rtl/note_voice_stack_unit.sv
tb/note_voice_stack_unit_test.sv
